FILE: src/fsr_pkg.sv
// Fan speed regulator package: shared types, codes and the level tables.
// Used by the step logic and the core top level.
package fsr_pkg;

    localparam logic [1:0] FUNC_SET   = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_POWER = 2'd2;

    localparam logic [1:0] CFG_DUTY_MIN      = 2'd0;
    localparam logic [1:0] CFG_DUTY_MAX      = 2'd1;
    localparam logic [1:0] CFG_STALL_SECONDS = 2'd2;

    localparam logic [7:0] DUTY_MIN_RESET      = 8'd20;
    localparam logic [7:0] DUTY_MAX_RESET      = 8'd160;
    localparam logic [5:0] STALL_SECONDS_RESET = 6'd15;

    localparam logic [7:0] GOOD_PULSES  = 8'd21;
    localparam logic [8:0] NEAR_BAND    = 9'd9;
    localparam logic [9:0] BIG_STEP     = 10'd4;
    localparam logic [9:0] SMALL_STEP   = 10'd1;
    localparam logic [7:0] SETTLE_TICKS = 8'd3;
    localparam logic [1:0] TOP_INTERVAL = 2'd1;
    localparam logic [1:0] LOW_INTERVAL = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] level;
        logic [7:0] pulse_count;
        logic       power_on;
        logic       abnormal_hold;
    } fsr_item_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       duty_written;
        logic       pwm_enabled;
        logic       stall_error;
    } fsr_result_t;

    typedef struct packed {
        logic [7:0] target_speed;
        logic [7:0] duty_value;
        logic [5:0] stall_count;
        logic [7:0] settle_count;
        logic [1:0] adjust_interval;
        logic       skip_first;
        logic       powered;
    } fsr_state_t;

    typedef struct packed {
        logic [7:0] duty_min;
        logic [7:0] duty_max;
        logic [5:0] stall_seconds;
    } fsr_cfg_t;

    // Entries past the last table row return the default value 135.
    function automatic logic [7:0] start_duty(input logic [5:0] idx);
        logic [7:0] v;
        case (idx)
            6'd0:  v = 8'd22;
            6'd1:  v = 8'd24;
            6'd2:  v = 8'd26;
            6'd3:  v = 8'd28;
            6'd4:  v = 8'd29;
            6'd5:  v = 8'd31;
            6'd6:  v = 8'd33;
            6'd7:  v = 8'd35;
            6'd8:  v = 8'd37;
            6'd9:  v = 8'd39;
            6'd10: v = 8'd41;
            6'd11: v = 8'd43;
            6'd12: v = 8'd46;
            6'd13: v = 8'd48;
            6'd14: v = 8'd50;
            6'd15: v = 8'd52;
            6'd16: v = 8'd55;
            6'd17: v = 8'd57;
            6'd18: v = 8'd59;
            6'd19: v = 8'd62;
            6'd20: v = 8'd64;
            6'd21: v = 8'd67;
            6'd22: v = 8'd70;
            6'd23: v = 8'd72;
            6'd24: v = 8'd75;
            6'd25: v = 8'd78;
            6'd26: v = 8'd81;
            6'd27: v = 8'd84;
            6'd28: v = 8'd86;
            6'd29: v = 8'd90;
            6'd30: v = 8'd93;
            6'd31: v = 8'd96;
            default: v = 8'd135;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] target_count(input logic [5:0] idx);
        logic [7:0] v;
        case (idx)
            6'd0:  v = 8'd43;
            6'd1:  v = 8'd46;
            6'd2:  v = 8'd50;
            6'd3:  v = 8'd53;
            6'd4:  v = 8'd56;
            6'd5:  v = 8'd60;
            6'd6:  v = 8'd63;
            6'd7:  v = 8'd66;
            6'd8:  v = 8'd69;
            6'd9:  v = 8'd73;
            6'd10: v = 8'd76;
            6'd11: v = 8'd79;
            6'd12: v = 8'd83;
            6'd13: v = 8'd86;
            6'd14: v = 8'd89;
            6'd15: v = 8'd93;
            6'd16: v = 8'd96;
            6'd17: v = 8'd99;
            6'd18: v = 8'd102;
            6'd19: v = 8'd106;
            6'd20: v = 8'd109;
            6'd21: v = 8'd112;
            6'd22: v = 8'd116;
            6'd23: v = 8'd119;
            6'd24: v = 8'd122;
            6'd25: v = 8'd126;
            6'd26: v = 8'd129;
            6'd27: v = 8'd132;
            6'd28: v = 8'd135;
            6'd29: v = 8'd139;
            6'd30: v = 8'd142;
            6'd31: v = 8'd145;
            default: v = 8'd180;
        endcase
        return v;
    endfunction

endpackage

FILE: src/fsr_item_if.sv
// Request channel for regulator items: valid/ready plus the item fields.
// Depends on nothing.
interface fsr_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [5:0] level;
    logic [7:0] pulse_count;
    logic       power_on;
    logic       abnormal_hold;

    modport source (output valid, func, level, pulse_count, power_on, abnormal_hold,
                    input ready);
    modport sink (input valid, func, level, pulse_count, power_on, abnormal_hold,
                  output ready);
endinterface

FILE: src/fsr_result_if.sv
// Result channel of the regulator: valid/ready plus the result fields.
// Depends on nothing.
interface fsr_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       duty_written;
    logic       pwm_enabled;
    logic       stall_error;

    modport source (output valid, duty, duty_written, pwm_enabled, stall_error,
                    input ready);
    modport sink (input valid, duty, duty_written, pwm_enabled, stall_error,
                  output ready);
endinterface

FILE: src/fsr_step.sv
// Next-state and result logic for one regulator request.
// Depends on fsr_pkg.
module fsr_step #(
    parameter int LEVELS = 33
) (
    input  fsr_pkg::fsr_cfg_t    cfg,
    input  fsr_pkg::fsr_state_t  state,
    input  fsr_pkg::fsr_item_t   item,
    output fsr_pkg::fsr_state_t  state_next,
    output fsr_pkg::fsr_result_t res
);

    localparam logic [6:0] LEVELS_V = 7'(LEVELS);

    logic [6:0]       level_ext;
    logic [5:0]       tab_idx;
    logic [7:0]       settle_dec;
    logic [5:0]       stall_inc;
    logic             up;
    logic             big_up;
    logic             down;
    logic             big_down;
    logic signed [9:0] d_sum;
    logic [7:0]       d_clamped;
    logic             written;
    logic             stall;

    assign level_ext = {1'b0, item.level};
    assign tab_idx   = item.level - 6'd1;
    assign settle_dec = state.settle_count - 8'd1;
    assign stall_inc  = state.stall_count + 6'd1;

    assign up       = state.target_speed > item.pulse_count;
    assign big_up   = {1'b0, state.target_speed} > ({1'b0, item.pulse_count} + fsr_pkg::NEAR_BAND);
    assign down     = state.target_speed < item.pulse_count;
    assign big_down = ({1'b0, state.target_speed} + fsr_pkg::NEAR_BAND) < {1'b0, item.pulse_count};

    always_comb
    begin
        d_sum = $signed({2'b00, state.duty_value});
        if (up)
        begin
            d_sum = d_sum + $signed(big_up ? fsr_pkg::BIG_STEP : fsr_pkg::SMALL_STEP);
        end
        else if (down)
        begin
            d_sum = d_sum - $signed(big_down ? fsr_pkg::BIG_STEP : fsr_pkg::SMALL_STEP);
        end
        if (d_sum >= $signed({2'b00, cfg.duty_max}))
        begin
            d_clamped = cfg.duty_max;
        end
        else if (d_sum <= $signed({2'b00, cfg.duty_min}))
        begin
            d_clamped = cfg.duty_min;
        end
        else
        begin
            d_clamped = d_sum[7:0];
        end
    end

    always_comb
    begin
        state_next = state;
        written    = 1'b0;
        stall      = 1'b0;
        unique case (item.func)
            fsr_pkg::FUNC_SET:
            begin
                if (item.level != 6'd0)
                begin
                    if (level_ext <= LEVELS_V)
                    begin
                        state_next.target_speed = fsr_pkg::target_count(tab_idx);
                        state_next.duty_value   = fsr_pkg::start_duty(tab_idx);
                        written = 1'b1;
                    end
                    state_next.adjust_interval = (level_ext == LEVELS_V) ?
                        fsr_pkg::TOP_INTERVAL : fsr_pkg::LOW_INTERVAL;
                    state_next.skip_first   = 1'b1;
                    state_next.settle_count = fsr_pkg::SETTLE_TICKS;
                end
            end
            fsr_pkg::FUNC_TICK:
            begin
                if (!item.abnormal_hold)
                begin
                    if (state.powered)
                    begin
                        if (item.pulse_count > fsr_pkg::GOOD_PULSES)
                        begin
                            state_next.settle_count = settle_dec;
                            if (settle_dec == 8'd0)
                            begin
                                state_next.settle_count = {6'd0, state.adjust_interval};
                                if (state.skip_first)
                                begin
                                    state_next.skip_first = 1'b0;
                                end
                                else
                                begin
                                    state_next.duty_value = d_clamped;
                                    written = 1'b1;
                                end
                            end
                            state_next.stall_count = 6'd0;
                        end
                        else
                        begin
                            state_next.stall_count = stall_inc;
                            if (stall_inc >= cfg.stall_seconds)
                            begin
                                stall = 1'b1;
                                state_next.stall_count = 6'd0;
                            end
                        end
                    end
                    else
                    begin
                        state_next.stall_count = 6'd0;
                    end
                end
            end
            fsr_pkg::FUNC_POWER:
            begin
                state_next.powered = item.power_on;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    assign res.duty         = state_next.duty_value;
    assign res.duty_written = written;
    assign res.pwm_enabled  = state_next.powered;
    assign res.stall_error  = stall;

endmodule

FILE: src/fan_speed_regulator_core.sv
// Fan speed regulator core: request register, step logic, state and result register.
// Depends on fsr_pkg, fsr_item_if, fsr_result_if and fsr_step.
//
// Usage:
//   item   - request channel (valid/ready): set level, one-second tick with the
//            tach pulse count, or power change.
//   result - one result per request: duty, duty_written, pwm_enabled, stall_error.
//   cfg_*  - write port for duty_min, duty_max and stall_seconds; write only
//            while no request is in flight.
// Order: an accepted request waits in the request register and moves into the
//   result register when the result register advances; result.valid then rises
//   and the result can be taken while result.ready is high.
// Throughput: one request per cycle unless the result stalls; the request and
//   result registers form a two-stage pipeline, with all state updated in one
//   pass through the step logic as a request moves into the result register.
// Reset: rst_n clears both pipeline stages, loads the configuration defaults
//   (20, 160, 15) and the regulator state (interval 1, all else zero).
// Stall: when result.ready is low the result holds; the request register
//   still takes one more request, then item.ready drops until the result
//   is taken.
module fan_speed_regulator_core #(
    parameter int LEVELS = 33
) (
    input  logic                clk,
    input  logic                rst_n,
    fsr_item_if.sink            item,
    fsr_result_if.source        result,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_wdata
);

    fsr_pkg::fsr_cfg_t    cfg_reg;
    fsr_pkg::fsr_state_t  state_reg;
    fsr_pkg::fsr_state_t  state_next;
    fsr_pkg::fsr_item_t   item_reg;
    fsr_pkg::fsr_result_t res_reg;
    fsr_pkg::fsr_result_t res_next;
    logic                 item_valid_reg;
    logic                 item_valid_next;
    logic                 res_valid_reg;
    logic                 advance;
    logic                 item_accept;

    assign advance     = !res_valid_reg || result.ready;
    assign item.ready  = !item_valid_reg || advance;
    assign item_accept = item.valid && item.ready;

    assign item_valid_next = item_accept ? 1'b1 : (advance ? 1'b0 : item_valid_reg);

    fsr_step #(
        .LEVELS (LEVELS)
    ) u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_min      <= fsr_pkg::DUTY_MIN_RESET;
            cfg_reg.duty_max      <= fsr_pkg::DUTY_MAX_RESET;
            cfg_reg.stall_seconds <= fsr_pkg::STALL_SECONDS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fsr_pkg::CFG_DUTY_MIN:      cfg_reg.duty_min      <= cfg_wdata;
                fsr_pkg::CFG_DUTY_MAX:      cfg_reg.duty_max      <= cfg_wdata;
                fsr_pkg::CFG_STALL_SECONDS: cfg_reg.stall_seconds <= cfg_wdata[5:0];
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg.target_speed    <= 8'd0;
            state_reg.duty_value      <= 8'd0;
            state_reg.stall_count     <= 6'd0;
            state_reg.settle_count    <= 8'd0;
            state_reg.adjust_interval <= fsr_pkg::TOP_INTERVAL;
            state_reg.skip_first      <= 1'b0;
            state_reg.powered         <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (advance)
            begin
                res_valid_reg <= item_valid_reg;
                if (item_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg.func          <= item.func;
            item_reg.level         <= item.level;
            item_reg.pulse_count   <= item.pulse_count;
            item_reg.power_on      <= item.power_on;
            item_reg.abnormal_hold <= item.abnormal_hold;
        end
        if (advance && item_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.duty         = res_reg.duty;
    assign result.duty_written = res_reg.duty_written;
    assign result.pwm_enabled  = res_reg.pwm_enabled;
    assign result.stall_error  = res_reg.stall_error;

endmodule

FILE: src/fsr_checker.sv
// Port-level checker for the fan speed regulator core, bound to the top level.
// Depends on fan_speed_regulator_core and its result interface.
module fsr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_duty,
    input logic       res_duty_written,
    input logic       res_pwm_enabled,
    input logic       res_stall_error
);

    a_reset_no_result: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid right after reset");

    a_stall_needs_power: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall_error |-> res_pwm_enabled)
        else $error("stall reported while unpowered");

    a_stall_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_stall_error && res_duty_written))
        else $error("stall and duty write in one result");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_duty)
            && $stable(res_duty_written) && $stable(res_pwm_enabled)
            && $stable(res_stall_error))
        else $error("stalled result changed");

endmodule

bind fan_speed_regulator_core fsr_checker u_fsr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .res_duty         (result.duty),
    .res_duty_written (result.duty_written),
    .res_pwm_enabled  (result.pwm_enabled),
    .res_stall_error  (result.stall_error)
);
